// ----- hw/rtl/threshold_centroid_bbox_top_assert.svh -----
// Assertion macros for the threshold centroid and bounding box block.
// Expects signals clk and rst in the scope of use.
`ifndef THRESHOLD_CENTROID_BBOX_TOP_ASSERT_SVH
`define THRESHOLD_CENTROID_BBOX_TOP_ASSERT_SVH

// same-cycle implication
`define TCB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tcb_pkg.sv -----
// Shared types and constants for the threshold centroid and bounding box block.
// No dependencies.
package tcb_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 11;
  localparam int unsigned PIX_W  = 8;

  localparam int unsigned CENT_W  = 14;
  localparam int unsigned BOX_W   = 10;
  localparam int unsigned COUNT_W = 21;

  localparam logic [CFG_DW-1:0]  SIZE_RESET      = 11'd1024;
  localparam logic [PIX_W-1:0]   THRESHOLD_RESET = 8'd128;
  localparam logic [CENT_W-1:0]  CENT_MAX        = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

  typedef enum logic [CFG_AW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ON_THRESHOLD = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_flags_t;

  typedef struct packed {
    logic [CENT_W-1:0]  centroid_x;
    logic [CENT_W-1:0]  centroid_y;
    logic [BOX_W-1:0]   box_min_x;
    logic [BOX_W-1:0]   box_min_y;
    logic [BOX_W-1:0]   box_max_x;
    logic [BOX_W-1:0]   box_max_y;
    logic [COUNT_W-1:0] on_count;
    logic               empty_res;
  } result_t;

endpackage

// ----- hw/rtl/tcb_front.sv -----
// Front end: configuration registers, raster position tracking and per-frame accumulation.
// Depends on tcb_pkg.
module tcb_front import tcb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned XW  = $clog2(MAX_WIDTH),
  localparam int unsigned YW  = $clog2(MAX_HEIGHT),
  localparam int unsigned CW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int unsigned SXW = XW + CW,
  localparam int unsigned SYW = YW + CW,
  localparam int unsigned RW  = SXW + SYW + CW + 2 * XW + 2 * YW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [PIX_W-1:0]  pixel,
  input  queue_flags_t      flags,
  output logic              push,
  output logic [RW-1:0]     rec
);

  logic [XW-1:0]    last_col;
  logic [YW-1:0]    last_row;
  logic [PIX_W-1:0] on_threshold;
  logic [XW-1:0]    column;
  logic [YW-1:0]    row;
  logic [SXW-1:0]   sum_x, sum_x_next;
  logic [SYW-1:0]   sum_y, sum_y_next;
  logic [CW-1:0]    count, count_next;
  logic [XW-1:0]    least_x, least_x_next, most_x, most_x_next;
  logic [YW-1:0]    least_y, least_y_next, most_y, most_y_next;
  logic             accept, on, line_end, frame_end;

  function automatic int unsigned size_last(input logic [CFG_DW-1:0] v,
                                            input int unsigned maxv);
    int unsigned s;
    s = 32'(v);
    if (s == 0) s = 1;
    else if (s > maxv) s = maxv;
    return s - 1;
  endfunction

  assign s_tready  = !flags.full;
  assign accept    = s_tvalid && s_tready;
  assign push      = accept && frame_end;

  always_comb begin
    on           = pixel >= on_threshold;
    line_end     = column >= last_col;
    frame_end    = line_end && (row >= last_row);
    sum_x_next   = sum_x + (on ? SXW'(column) : '0);
    sum_y_next   = sum_y + (on ? SYW'(row) : '0);
    count_next   = count + CW'(on);
    least_x_next = (on && column < least_x) ? column : least_x;
    least_y_next = (on && row < least_y) ? row : least_y;
    most_x_next  = (on && column > most_x) ? column : most_x;
    most_y_next  = (on && row > most_y) ? row : most_y;
    rec = {sum_x_next, sum_y_next, count_next, least_x_next, least_y_next,
           most_x_next, most_y_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col     <= XW'(size_last(SIZE_RESET, MAX_WIDTH));
      last_row     <= YW'(size_last(SIZE_RESET, MAX_HEIGHT));
      on_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_FRAME_WIDTH:  last_col     <= XW'(size_last(cfg_data, MAX_WIDTH));
        REG_FRAME_HEIGHT: last_row     <= YW'(size_last(cfg_data, MAX_HEIGHT));
        REG_ON_THRESHOLD: on_threshold <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column  <= '0;
      row     <= '0;
      sum_x   <= '0;
      sum_y   <= '0;
      count   <= '0;
      least_x <= '1;
      least_y <= '1;
      most_x  <= '0;
      most_y  <= '0;
    end else if (accept) begin
      column <= line_end ? '0 : column + 1'b1;
      if (line_end) begin
        row <= frame_end ? '0 : row + 1'b1;
      end
      if (frame_end) begin
        sum_x   <= '0;
        sum_y   <= '0;
        count   <= '0;
        least_x <= '1;
        least_y <= '1;
        most_x  <= '0;
        most_y  <= '0;
      end else begin
        sum_x   <= sum_x_next;
        sum_y   <= sum_y_next;
        count   <= count_next;
        least_x <= least_x_next;
        least_y <= least_y_next;
        most_x  <= most_x_next;
        most_y  <= most_y_next;
      end
    end
  end

endmodule

// ----- hw/rtl/tcb_queue.sv -----
// Short frame-record queue between front and back end.
// Depends on tcb_pkg.
module tcb_queue import tcb_pkg::*; #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output queue_flags_t  flags
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] fill;

  assign flags.full  = fill == NW'(DEPTH);
  assign flags.empty = fill == '0;
  assign pop_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// ----- hw/rtl/tcb_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on tcb_pkg only through the import convention.
module tcb_div import tcb_pkg::*; #(
  parameter int unsigned NW   = 16,
  parameter int unsigned DENW = 8,
  localparam int unsigned SW  = $clog2(NW + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   num,
  input  logic [DENW-1:0] den,
  output logic            busy,
  output logic [NW-1:0]   quo
);

  logic [SW-1:0]   steps;
  logic [DENW-1:0] den_q, rem;
  logic [NW-1:0]   acc;
  logic [DENW:0]   shifted, trial;
  logic            fits;

  assign busy = steps != '0;
  assign quo  = acc;

  always_comb begin
    shifted = {rem, acc[NW-1]};
    trial   = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= SW'(NW);
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      rem   <= '0;
      acc   <= num;
    end else if (busy) begin
      rem <= fits ? trial[DENW-1:0] : shifted[DENW-1:0];
      acc <= {acc[NW-2:0], fits};
    end
  end

endmodule

// ----- hw/rtl/tcb_back.sv -----
// Back end: pops frame records, divides for the centroids, holds the result beat.
// Depends on tcb_pkg and tcb_div.
module tcb_back import tcb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned XW  = $clog2(MAX_WIDTH),
  localparam int unsigned YW  = $clog2(MAX_HEIGHT),
  localparam int unsigned CW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int unsigned SXW = XW + CW,
  localparam int unsigned SYW = YW + CW,
  localparam int unsigned RW  = SXW + SYW + CW + 2 * XW + 2 * YW
) (
  input  logic          clk,
  input  logic          rst,
  input  queue_flags_t  flags,
  output logic          pop,
  input  logic [RW-1:0] rec,
  output logic          m_tvalid,
  input  logic          m_tready,
  output result_t       res
);

  back_state_t     state, state_next;
  logic            load_out, busy_x, busy_y, empty;
  logic [RW-1:0]   rec_q;
  logic [SXW-1:0]  r_sum_x;
  logic [SYW-1:0]  r_sum_y;
  logic [CW-1:0]   r_count;
  logic [XW-1:0]   r_least_x, r_most_x;
  logic [YW-1:0]   r_least_y, r_most_y;
  logic [SXW+3:0]  quo_x;
  logic [SYW+3:0]  quo_y;
  result_t         res_next;

  assign {r_sum_x, r_sum_y, r_count, r_least_x, r_least_y, r_most_x, r_most_y} = rec_q;

  tcb_div #(.NW(SXW + 4), .DENW(CW)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (pop),
    .num   ({rec[RW-1 -: SXW], 4'b0}),
    .den   (rec[RW-SXW-SYW-1 -: CW]),
    .busy  (busy_x),
    .quo   (quo_x)
  );

  tcb_div #(.NW(SYW + 4), .DENW(CW)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (pop),
    .num   ({rec[RW-SXW-1 -: SYW], 4'b0}),
    .den   (rec[RW-SXW-SYW-1 -: CW]),
    .busy  (busy_y),
    .quo   (quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!flags.empty) begin
          pop        = 1'b1;
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!busy_x && !busy_y) state_next = BK_DONE;
      end
      BK_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    empty    = r_count == '0;
    res_next = '0;
    res_next.empty_res = empty;
    if (!empty) begin
      res_next.centroid_x = (64'(quo_x) > 64'(CENT_MAX)) ? CENT_MAX : CENT_W'(quo_x);
      res_next.centroid_y = (64'(quo_y) > 64'(CENT_MAX)) ? CENT_MAX : CENT_W'(quo_y);
      res_next.box_min_x  = BOX_W'(r_least_x);
      res_next.box_min_y  = BOX_W'(r_least_y);
      res_next.box_max_x  = BOX_W'(r_most_x);
      res_next.box_max_y  = BOX_W'(r_most_y);
      res_next.on_count   = (64'(r_count) > 64'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(r_count);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rec_q <= rec;
    if (load_out) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/threshold_centroid_bbox_top.sv -----
// Binary blob centroid and bounding box over a raster grey frame: one pixel beat per
// cycle in, one result beat per frame out. s_tready drops only while both entries of
// the frame queue are full. After a frame's last pixel the back end divides for the
// centroids (restoring divider, one quotient bit per cycle), so frames shorter than
// the divide back up into the queue and then stall the input. Frame size writes take
// effect on the next line or frame boundary check.
`include "threshold_centroid_bbox_top_assert.svh"
module threshold_centroid_bbox_top import tcb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned XW  = $clog2(MAX_WIDTH),
  localparam int unsigned YW  = $clog2(MAX_HEIGHT),
  localparam int unsigned CW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int unsigned RW  = 2 * CW + XW + YW + CW + 2 * XW + 2 * YW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // pixel[7:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  // centroid_x[13:0], centroid_y[27:14], box_min_x[37:28], box_min_y[47:38],
  // box_max_x[57:48], box_max_y[67:58], on_count[88:68], zero fill[95:89]
  output logic [95:0]       m_tdata,
  output logic              m_tuser    // empty_res
);

  queue_flags_t  q_flags;
  logic          push, pop;
  logic [RW-1:0] push_rec, pop_rec;
  result_t       res;

  tcb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .pixel    (s_tdata),
    .flags    (q_flags),
    .push     (push),
    .rec      (push_rec)
  );

  tcb_queue #(.DW(RW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .pop       (pop),
    .pop_data  (pop_rec),
    .flags     (q_flags)
  );

  tcb_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk      (clk),
    .rst      (rst),
    .flags    (q_flags),
    .pop      (pop),
    .rec      (pop_rec),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = {7'b0, res.on_count, res.box_max_y, res.box_max_x, res.box_min_y,
                    res.box_min_x, res.centroid_y, res.centroid_x};
  assign m_tuser = res.empty_res;

  `TCB_ASSERT_SAME(a_push_room, push, !q_flags.full, "frame record pushed into full queue")
  `TCB_ASSERT_SAME(a_pop_data, pop, !q_flags.empty, "frame record popped from empty queue")
  `TCB_ASSERT_NEXT(a_pop_frees, pop, !q_flags.full, "queue full right after a pop")
  `TCB_ASSERT_SAME(a_empty_count, m_tvalid, m_tuser == (m_tdata[88:68] == 21'd0),
                   "empty flag disagrees with on_count")

endmodule

// ----- dv/threshold_centroid_bbox_top_tb.sv -----
// Self-checking bench for threshold_centroid_bbox_top: streams grey frames in
// raster order and scores every per-frame centroid and bounding box result.
// Depends on tcb_pkg and the block's RTL; the expected results come from a local model.
`timescale 1ns / 100ps
module threshold_centroid_bbox_top_tb;
  import tcb_pkg::*;

  localparam int unsigned MAX_W         = MAX_WIDTH_DEF;
  localparam int unsigned MAX_H         = MAX_HEIGHT_DEF;
  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned FINAL_CYCLES  = 100;
  localparam int unsigned LONG_HOLD     = 400;
  localparam longint unsigned TIMEOUT_NS = 5_000_000;
  localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;

  typedef enum int {PAT_NOISE, PAT_DARK, PAT_BRIGHT, PAT_BLOB} frame_style_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic m_tuser;

  threshold_centroid_bbox_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  logic [7:0] pixel_q[$];
  result_t frame_results_due[$];

  logic [CFG_DW-1:0] width_reg  = SIZE_RESET;
  logic [CFG_DW-1:0] height_reg = SIZE_RESET;
  logic [PIX_W-1:0]  thresh_reg = THRESHOLD_RESET;

  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  longint unsigned sum_col = 0;
  longint unsigned sum_row = 0;
  int unsigned on_total = 0;
  int unsigned min_col = 32'hFFFF_FFFF;
  int unsigned min_row = 32'hFFFF_FFFF;
  int unsigned max_col = 0;
  int unsigned max_row = 0;

  int unsigned errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned frames_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned random_items = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_size(input logic [CFG_DW-1:0] raw,
                                              input int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return 32'(raw);
  endfunction

  function automatic logic [CENT_W-1:0] mean_q4(input longint unsigned sum,
                                                input int unsigned cnt);
    longint unsigned q;
    q = (sum * 16) / cnt;
    return (q > CENT_MAX) ? CENT_MAX : q[CENT_W-1:0];
  endfunction

  task automatic accumulate_pixel(input logic [7:0] pix);
    int unsigned w;
    int unsigned h;
    bit line_end;
    bit frame_end;
    result_t r;
    w = active_size(width_reg, MAX_W);
    h = active_size(height_reg, MAX_H);
    if (pix >= thresh_reg) begin
      sum_col += col_pos;
      sum_row += row_pos;
      on_total++;
      if (col_pos < min_col) min_col = col_pos;
      if (row_pos < min_row) min_row = row_pos;
      if (col_pos > max_col) max_col = col_pos;
      if (row_pos > max_row) max_row = row_pos;
    end
    line_end = col_pos >= w - 1;
    frame_end = line_end && row_pos >= h - 1;
    if (!line_end) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (!frame_end) begin
        row_pos++;
      end else begin
        row_pos = 0;
        r = '0;
        if (on_total == 0) begin
          r.empty_res = 1'b1;
        end else begin
          r.centroid_x = mean_q4(sum_col, on_total);
          r.centroid_y = mean_q4(sum_row, on_total);
          r.box_min_x = min_col[BOX_W-1:0];
          r.box_min_y = min_row[BOX_W-1:0];
          r.box_max_x = max_col[BOX_W-1:0];
          r.box_max_y = max_row[BOX_W-1:0];
          r.on_count = (on_total > COUNT_MAX) ? COUNT_MAX : on_total[COUNT_W-1:0];
        end
        frame_results_due.push_back(r);
        sum_col = 0;
        sum_row = 0;
        on_total = 0;
        min_col = 32'hFFFF_FFFF;
        min_row = 32'hFFFF_FFFF;
        max_col = 0;
        max_row = 0;
      end
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // pixel driver: bursts and gaps, hold the beat while stalled
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        s_tdata <= pixel_q.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      accumulate_pixel(s_tdata);
      pixels_sent++;
    end
  end

  // result receiver: stall pattern plus requested long hold-offs
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(1, 0);
        2: m_tready <= ($urandom_range(3, 0) == 0);
        default: m_tready <= ($urandom_range(4, 0) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (frame_results_due.size() == 0) begin
        $display("%0t: result beat with no frame pending, expected none, actual %h/%b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("centroid_x", want.centroid_x, m_tdata[13:0]);
        check_field("centroid_y", want.centroid_y, m_tdata[27:14]);
        check_field("box_min_x", want.box_min_x, m_tdata[37:28]);
        check_field("box_min_y", want.box_min_y, m_tdata[47:38]);
        check_field("box_max_x", want.box_max_x, m_tdata[57:48]);
        check_field("box_max_y", want.box_max_y, m_tdata[67:58]);
        check_field("on_count", want.on_count, m_tdata[88:68]);
        check_field("zero_fill", 0, m_tdata[95:89]);
        check_field("empty_res", want.empty_res, m_tuser);
        frames_checked++;
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      REG_FRAME_WIDTH:  width_reg = val;
      REG_FRAME_HEIGHT: height_reg = val;
      REG_ON_THRESHOLD: thresh_reg = val[PIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_settle(input int unsigned cycles);
    while (pixel_q.size() != 0 || s_tvalid || frame_results_due.size() != 0)
      @(negedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic queue_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) pixel_q.push_back($urandom_range(255, 0));
  endtask

  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input int unsigned thr);
    frame_style_t style;
    int unsigned x0, x1, y0, y1;
    logic [7:0] dark, bright;
    style = frame_style_t'($urandom_range(3, 0));
    x0 = $urandom_range(w - 1, 0);
    x1 = $urandom_range(w - 1, x0);
    y0 = $urandom_range(h - 1, 0);
    y1 = $urandom_range(h - 1, y0);
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        dark = (thr == 0) ? 8'd0 : $urandom_range(thr - 1, 0);
        bright = $urandom_range(255, thr);
        case (style)
          PAT_NOISE:  pixel_q.push_back($urandom_range(255, 0));
          PAT_DARK:   pixel_q.push_back(dark);
          PAT_BRIGHT: pixel_q.push_back(bright);
          default:    pixel_q.push_back((x >= x0 && x <= x1 && y >= y0 && y <= y1) ?
                                        bright : dark);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_DW-1:0] raw_w, raw_h;
    int unsigned eff_w, eff_h, thr, frames;
    logic [7:0] frame_a[12] = '{8'd127, 8'd128, 8'd0, 8'd255, 8'd0, 8'd0, 8'd200, 8'd0,
                                8'd129, 8'd0, 8'd0, 8'd127};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // small frame at the reset threshold, then an empty one
    write_reg(REG_FRAME_WIDTH, 11'd4);
    write_reg(REG_FRAME_HEIGHT, 11'd3);
    foreach (frame_a[i]) pixel_q.push_back(frame_a[i]);
    repeat (12) pixel_q.push_back(8'd127);
    drain_and_settle(SETTLE_CYCLES);

    // zero width acts as one, threshold zero with upper data bits set
    write_reg(REG_FRAME_WIDTH, 11'd0);
    write_reg(REG_FRAME_HEIGHT, 11'd1);
    write_reg(REG_ON_THRESHOLD, 11'h700);
    pixel_q.push_back(8'd0);
    pixel_q.push_back(8'd255);
    pixel_q.push_back(8'd85);
    pixel_q.push_back(8'd170);
    drain_and_settle(SETTLE_CYCLES);

    // oversized width keeps the line open, a zero width then closes it
    write_reg(REG_FRAME_WIDTH, 11'h7FF);
    write_reg(REG_ON_THRESHOLD, 11'd255);
    for (int unsigned x = 0; x < 30; x++)
      pixel_q.push_back((x == 0 || x == 29 || $urandom_range(7, 0) == 0) ?
                        8'd255 : $urandom_range(254, 0));
    drain_and_settle(SETTLE_CYCLES);
    write_reg(REG_FRAME_WIDTH, 11'd0);
    pixel_q.push_back(8'd255);
    drain_and_settle(SETTLE_CYCLES);

    // oversized height keeps the frame open, a zero height then closes it
    write_reg(REG_FRAME_WIDTH, 11'd2);
    write_reg(REG_FRAME_HEIGHT, 11'h7FF);
    write_reg(REG_ON_THRESHOLD, 11'd200);
    queue_noise(24);
    drain_and_settle(SETTLE_CYCLES);
    write_reg(REG_FRAME_HEIGHT, 11'd0);
    queue_noise(2);
    drain_and_settle(SETTLE_CYCLES);

    // one-pixel frames against a long receiver hold-off
    write_reg(REG_FRAME_WIDTH, 11'd1);
    write_reg(REG_FRAME_HEIGHT, 11'd1);
    write_reg(REG_ON_THRESHOLD, 11'd128);
    hold_requests++;
    queue_noise(40);
    drain_and_settle(SETTLE_CYCLES);

    // shrink the frame while a frame is partly in
    write_reg(REG_FRAME_WIDTH, 11'd8);
    write_reg(REG_FRAME_HEIGHT, 11'd4);
    write_reg(REG_ON_THRESHOLD, 11'd100);
    queue_noise(29);
    drain_and_settle(SETTLE_CYCLES);
    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_SPARE, 11'h7FF);
    queue_noise(10);
    drain_and_settle(SETTLE_CYCLES);
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    queue_noise(20);
    drain_and_settle(SETTLE_CYCLES);

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(9, 0))
        0: raw_w = 11'd0;
        1: raw_w = $urandom_range(48, 13);
        default: raw_w = $urandom_range(12, 1);
      endcase
      raw_h = ($urandom_range(9, 0) == 0) ? 11'd0 : $urandom_range(8, 1);
      case ($urandom_range(7, 0))
        0: thr = 0;
        1: thr = 255;
        default: thr = $urandom_range(255, 0);
      endcase
      eff_w = active_size(raw_w, MAX_W);
      eff_h = active_size(raw_h, MAX_H);
      write_reg(REG_FRAME_WIDTH, raw_w);
      write_reg(REG_FRAME_HEIGHT, raw_h);
      write_reg(REG_ON_THRESHOLD, {3'($urandom_range(7, 0)), 8'(thr)});
      if ($urandom_range(7, 0) == 0) write_reg(REG_SPARE, $urandom_range(2047, 0));
      frames = $urandom_range(4, 1);
      repeat (frames) begin
        queue_frame(eff_w, eff_h, thr);
        random_items += eff_w * eff_h;
      end
      // queue up to a frame of extra pixels so the next size write can land mid-frame
      if ($urandom_range(5, 0) == 0) begin
        frames = $urandom_range(eff_w * eff_h, 1);
        queue_noise(frames);
        random_items += frames;
      end
      drain_and_settle(SETTLE_CYCLES);
    end

    drain_and_settle(FINAL_CYCLES);
    $display("Covered %0d pixel beats and %0d frame results across %0d register writes,",
             pixels_sent, frames_checked, reg_writes);
    $display("including clamped sizes, mid-frame resizes and a long output hold-off.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d frame results outstanding", frame_results_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
